// File: rtl/core/ogru_pkg.sv
// Shared types and constants of the occupancy grid ray update block.
package ogru_pkg;

    // item kinds
    localparam logic KIND_RAY  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // configuration register indexes
    localparam logic [2:0] REG_PASS_CHANGE       = 3'd0;
    localparam logic [2:0] REG_ZERO_RANGE_CHANGE = 3'd1;
    localparam logic [2:0] REG_HIT_CHANGE        = 3'd2;
    localparam logic [2:0] REG_HIT_DEPTH         = 3'd3;
    localparam logic [2:0] REG_MAX_RANGE         = 3'd4;
    localparam logic [2:0] REG_SAMPLE_STEP       = 3'd5;

    localparam int CELL_W  = 16;    // stored Q8.8 log-odds
    localparam int DELTA_W = 13;    // signed cell change
    localparam int COUNT_W = 11;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

    // clamp at +-50.0 in Q8.8
    localparam logic signed [CELL_W:0] CLAMP_HI = 17'sd12800;
    localparam logic signed [CELL_W:0] CLAMP_LO = -17'sd12800;

    // half of one Q1.15 unit, for round to nearest
    localparam int Q15_SHIFT = 15;
    localparam int Q15_HALF  = 16384;

    typedef struct packed {
        logic               kind;
        logic [15:0]        pose_north;
        logic [15:0]        pose_east;
        logic signed [15:0] beam_cos;
        logic signed [15:0] beam_sin;
        logic [17:0]        range;
        logic [7:0]         cell_row;
        logic [7:0]         cell_col;
    } req_t;

    typedef struct packed {
        logic signed [14:0]   log_odds;
        logic                 occupied;
        logic [COUNT_W-1:0]   cells_updated;
    } rsp_t;

    typedef struct packed {
        logic [2:0]  index;
        logic [17:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic [11:0] pass_change;
        logic [11:0] zero_range_change;
        logic [11:0] hit_change;
        logic [15:0] hit_depth;
        logic [17:0] max_range;
        logic [11:0] sample_step;
    } cfg_t;

    // sample handed from the ray walker to the cell updater
    typedef struct packed {
        logic                      valid;
        logic signed [DELTA_W-1:0] delta;
    } sample_t;

    // cell write from the updater
    typedef struct packed {
        logic                     en;
        logic signed [CELL_W-1:0] data;
    } cell_wr_t;

endpackage

// File: rtl/core/ogru_chan_if.sv
// Valid/ready channel carrying one payload item.
interface ogru_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/occupancy_grid_ray_update.sv
// Top level of the log-odds occupancy grid: ray updates and cell reads.
//
//   channel  direction  payload     role
//   req      sink       ogru req_t  ray item or cell read item
//   rsp      source     ogru rsp_t  one result item per request item
//   cfg      sink       cfg_wr_t    register write, index and data, always ready
//
// A read item passes from acceptance through a RAM read state to its result in
// the output register; a ray item walks up to MAX_SAMPLES samples, with one
// cell read-modify-write per sample on the grid RAM.
// A ray with an unusable range goes to the output step with no walk.
// Reset: a clearing pass writes zero to all GRID_DIM * GRID_DIM cells, one per
// cycle; req.ready stays low until it ends.
// Stalls: the next item is taken while a result waits in the output register;
// a finished item waits in its own holding register until that slot frees.
module occupancy_grid_ray_update #(
    parameter int GRID_DIM    = 256,
    parameter int MAX_SAMPLES = 2048,
    parameter int FRAC_BITS   = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    ogru_chan_if.sink    req,
    ogru_chan_if.source  rsp,
    ogru_chan_if.sink    cfg
);
    import ogru_pkg::*;

    localparam int DEPTH  = GRID_DIM * GRID_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_PUT   = 3'd4;

    logic [2:0]               state_reg;
    logic [2:0]               state_next;
    logic [ADDR_W-1:0]        clr_addr_reg;
    logic                     rd_inside_reg;
    logic signed [CELL_W-1:0] res_value_reg;
    logic [COUNT_W-1:0]       res_count_reg;
    logic                     rsp_valid_reg;
    rsp_t                     rsp_payload_reg;

    cfg_t                     regs;
    sample_t                  smp;
    logic [ADDR_W-1:0]        smp_addr;
    logic                     walk_done;
    logic [COUNT_W-1:0]       walk_count;
    cell_wr_t                 wr;
    logic [ADDR_W-1:0]        wr_addr;

    logic                     accept;
    logic                     start;
    logic                     slot_free;
    logic                     read_inside;
    logic [ADDR_W-1:0]        read_addr;
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [CELL_W-1:0]        ram_wdata;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [CELL_W-1:0]        ram_rdata;
    logic signed [CELL_W-1:0] cell_val;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign slot_free = !rsp_valid_reg || rsp.ready;
    assign cell_val  = $signed(ram_rdata);

    // cell read item: an index past the grid reads as zero
    assign read_inside = (32'(req.payload.cell_row) < GRID_DIM)
                      && (32'(req.payload.cell_col) < GRID_DIM);
    assign read_addr   = ADDR_W'(32'(req.payload.cell_row) * GRID_DIM
                                 + 32'(req.payload.cell_col));

    // start the walk only for a ray with a usable range
    assign start = accept && (req.payload.kind == KIND_RAY)
                && (req.payload.range < regs.max_range);

    ogru_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    ogru_sampler #(
        .GRID_DIM    (GRID_DIM),
        .MAX_SAMPLES (MAX_SAMPLES),
        .FRAC_BITS   (FRAC_BITS),
        .ADDR_W      (ADDR_W)
    ) u_sampler (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .pose_north    (req.payload.pose_north),
        .pose_east     (req.payload.pose_east),
        .beam_cos      (req.payload.beam_cos),
        .beam_sin      (req.payload.beam_sin),
        .range         (req.payload.range),
        .cfg           (regs),
        .smp           (smp),
        .smp_addr      (smp_addr),
        .done          (walk_done),
        .cells_updated (walk_count)
    );

    ogru_cell_update #(
        .ADDR_W (ADDR_W)
    ) u_update (
        .clk      (clk),
        .rst_n    (rst_n),
        .smp      (smp),
        .smp_addr (smp_addr),
        .rdata    (cell_val),
        .wr       (wr),
        .wr_addr  (wr_addr)
    );

    // RAM ports: the clearing pass owns the write side after reset; reads
    // come from a read item in idle and from the walker otherwise
    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = wr.en;
            ram_waddr = wr_addr;
            ram_wdata = wr.data;
        end
        ram_raddr = (state_reg == S_IDLE) ? read_addr : smp_addr;
    end

    ogru_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // control sequence
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    priority if (req.payload.kind == KIND_READ)
                    begin
                        state_next = S_READ;
                    end
                    else if (start)
                    begin
                        state_next = S_WALK;
                    end
                    else
                    begin
                        state_next = S_PUT;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_PUT;
            end
            S_WALK:
            begin
                // the last sample's write lands in the cycle the walker stops
                if (walk_done)
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if ((state_reg == S_PUT) && slot_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // result holding and output registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_inside_reg <= read_inside;
            res_value_reg <= '0;
            res_count_reg <= '0;
        end
        if (state_reg == S_READ)
        begin
            res_value_reg <= rd_inside_reg ? cell_val : '0;
        end
        if ((state_reg == S_WALK) && walk_done)
        begin
            res_count_reg <= walk_count;
        end
        if ((state_reg == S_PUT) && slot_free)
        begin
            rsp_payload_reg.log_odds      <= res_value_reg[14:0];
            rsp_payload_reg.occupied      <= (res_value_reg > 0);
            rsp_payload_reg.cells_updated <= res_count_reg;
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_payload_reg;
endmodule

// File: rtl/core/ogru_ram.sv
// Generic simple dual-port RAM with registered read.
module ogru_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // a read of the address being written returns the old data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/core/ogru_cfg_regs.sv
// Configuration register file of the occupancy grid block.
module ogru_cfg_regs (
    input  logic           clk,
    input  logic           rst_n,
    ogru_chan_if.sink      cfg,
    output ogru_pkg::cfg_t regs
);
    import ogru_pkg::*;

    cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.pass_change       <= 12'd128;
            regs_reg.zero_range_change <= 12'd25;
            regs_reg.hit_change        <= 12'd256;
            regs_reg.hit_depth         <= 16'd256;
            regs_reg.max_range         <= 18'd262143;
            regs_reg.sample_step       <= 12'd128;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.payload.index)
                REG_PASS_CHANGE:       regs_reg.pass_change       <= cfg.payload.data[11:0];
                REG_ZERO_RANGE_CHANGE: regs_reg.zero_range_change <= cfg.payload.data[11:0];
                REG_HIT_CHANGE:        regs_reg.hit_change        <= cfg.payload.data[11:0];
                REG_HIT_DEPTH:         regs_reg.hit_depth         <= cfg.payload.data[15:0];
                REG_MAX_RANGE:         regs_reg.max_range         <= cfg.payload.data[17:0];
                REG_SAMPLE_STEP:       regs_reg.sample_step       <= cfg.payload.data[11:0];
                default:               ;   // unused index: drop
            endcase
        end
    end
endmodule

// File: rtl/core/ogru_sampler.sv
// Ray walker: steps sample points along the beam and issues cell addresses.
module ogru_sampler #(
    parameter int GRID_DIM    = 256,
    parameter int MAX_SAMPLES = 2048,
    parameter int FRAC_BITS   = 8,
    parameter int ADDR_W      = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [15:0]                   pose_north,
    input  logic [15:0]                   pose_east,
    input  logic signed [15:0]            beam_cos,
    input  logic signed [15:0]            beam_sin,
    input  logic [17:0]                   range,
    input  ogru_pkg::cfg_t                cfg,
    output ogru_pkg::sample_t             smp,
    output logic [ADDR_W-1:0]             smp_addr,
    output logic                          done,
    output logic [ogru_pkg::COUNT_W-1:0]  cells_updated
);
    import ogru_pkg::*;

    localparam int K_W    = $clog2(MAX_SAMPLES + 1);
    localparam int D_W    = K_W + 12;
    localparam int ACC_W  = D_W + 17;
    localparam int INC_W  = 29;
    localparam int ROW_W  = $clog2(GRID_DIM);
    localparam int POS_A  = ACC_W - 14;
    localparam int POS_B  = ROW_W + FRAC_BITS + 2;
    localparam int POS_W  = (POS_A > POS_B) ? POS_A : POS_B;
    localparam int CMP_W  = (D_W > 19) ? D_W : 19;
    localparam logic signed [POS_W-1:0] LIMIT = POS_W'((GRID_DIM - 1) << FRAC_BITS);
    localparam logic signed [POS_W-1:0] HALF  = POS_W'(1 << (FRAC_BITS - 1));
    localparam logic [K_W-1:0]          K_END = K_W'(MAX_SAMPLES);

    logic                     active_reg;
    logic [K_W-1:0]           k_reg;
    logic [D_W-1:0]           d_reg;
    logic signed [ACC_W-1:0]  acc_n_reg;
    logic signed [ACC_W-1:0]  acc_e_reg;
    logic signed [INC_W-1:0]  inc_n_reg;
    logic signed [INC_W-1:0]  inc_e_reg;
    logic [15:0]              pn_reg;
    logic [15:0]              pe_reg;
    logic [17:0]              range_reg;
    logic [COUNT_W-1:0]       count_reg;

    logic signed [ACC_W-16:0] off_n;
    logic signed [ACC_W-16:0] off_e;
    logic signed [POS_W-1:0]  pos_n;
    logic signed [POS_W-1:0]  pos_e;
    logic signed [POS_W-1:0]  rnd_n;
    logic signed [POS_W-1:0]  rnd_e;
    logic [ROW_W-1:0]         row;
    logic [ROW_W-1:0]         col;
    logic                     on_grid;
    logic                     range_zero;
    logic                     in_pass;
    logic                     in_hit;
    logic                     go;

    // accumulators hold beam * d plus half a Q1.15 unit, so the shift rounds
    assign off_n = acc_n_reg[ACC_W-1:Q15_SHIFT];
    assign off_e = acc_e_reg[ACC_W-1:Q15_SHIFT];

    always_comb
    begin
        pos_n = $signed({{(POS_W-16){1'b0}}, pn_reg}) + POS_W'(off_n);
        pos_e = $signed({{(POS_W-16){1'b0}}, pe_reg}) + POS_W'(off_e);
        rnd_n = pos_n + HALF;
        rnd_e = pos_e + HALF;
        row   = rnd_n[FRAC_BITS +: ROW_W];
        col   = rnd_e[FRAC_BITS +: ROW_W];
        on_grid = (pos_n > 0) && (pos_n < LIMIT) && (pos_e > 0) && (pos_e < LIMIT);

        range_zero = (range_reg == 18'd0);
        in_pass    = CMP_W'(range_reg) > CMP_W'(d_reg);
        in_hit     = (CMP_W'(range_reg) + CMP_W'(cfg.hit_depth)) > CMP_W'(d_reg);

        go   = active_reg && (k_reg != K_END) && on_grid && (range_zero || in_pass || in_hit);
        done = active_reg && !go;

        smp.valid = go;
        priority if (range_zero)
        begin
            smp.delta = -$signed({1'b0, cfg.zero_range_change});
        end
        else if (in_pass)
        begin
            smp.delta = -$signed({1'b0, cfg.pass_change});
        end
        else
        begin
            smp.delta = $signed({1'b0, cfg.hit_change});
        end

        smp_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(GRID_DIM)) + ADDR_W'(col);
    end

    assign cells_updated = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            k_reg      <= '0;
            count_reg  <= '0;
        end
        else if (start)
        begin
            active_reg <= 1'b1;
            k_reg      <= '0;
            count_reg  <= '0;
        end
        else if (go)
        begin
            k_reg <= k_reg + K_W'(1);
            if (count_reg != COUNT_MAX)
            begin
                count_reg <= count_reg + COUNT_W'(1);
            end
        end
        else if (done)
        begin
            active_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            d_reg     <= '0;
            acc_n_reg <= ACC_W'(Q15_HALF);
            acc_e_reg <= ACC_W'(Q15_HALF);
            inc_n_reg <= beam_cos * $signed({1'b0, cfg.sample_step});
            inc_e_reg <= beam_sin * $signed({1'b0, cfg.sample_step});
            pn_reg    <= pose_north;
            pe_reg    <= pose_east;
            range_reg <= range;
        end
        else if (go)
        begin
            d_reg     <= d_reg + D_W'(cfg.sample_step);
            acc_n_reg <= acc_n_reg + ACC_W'(inc_n_reg);
            acc_e_reg <= acc_e_reg + ACC_W'(inc_e_reg);
        end
    end
endmodule

// File: rtl/core/ogru_cell_update.sv
// Read-modify-write stage: adds the change to a cell, clamps, forwards.
module ogru_cell_update #(
    parameter int ADDR_W = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ogru_pkg::sample_t                     smp,
    input  logic [ADDR_W-1:0]                     smp_addr,
    input  logic signed [ogru_pkg::CELL_W-1:0]    rdata,
    output ogru_pkg::cell_wr_t                    wr,
    output logic [ADDR_W-1:0]                     wr_addr
);
    import ogru_pkg::*;

    logic                       w_valid_reg;
    logic [ADDR_W-1:0]          w_addr_reg;
    logic signed [DELTA_W-1:0]  w_delta_reg;
    logic                       fwd_valid_reg;
    logic [ADDR_W-1:0]          fwd_addr_reg;
    logic signed [CELL_W-1:0]   fwd_data_reg;

    logic signed [CELL_W-1:0]   old_val;
    logic signed [CELL_W:0]     sum;
    logic signed [CELL_W-1:0]   new_val;

    always_comb
    begin
        // the RAM returned the value before last cycle's write: take the bypass
        old_val = (fwd_valid_reg && (fwd_addr_reg == w_addr_reg)) ? fwd_data_reg : rdata;
        sum     = (CELL_W+1)'(old_val) + (CELL_W+1)'(w_delta_reg);
        priority if (sum > CLAMP_HI)
        begin
            new_val = CELL_W'(CLAMP_HI);
        end
        else if (sum < CLAMP_LO)
        begin
            new_val = CELL_W'(CLAMP_LO);
        end
        else
        begin
            new_val = CELL_W'(sum);
        end
    end

    assign wr.en   = w_valid_reg;
    assign wr.data = new_val;
    assign wr_addr = w_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            w_valid_reg   <= smp.valid;
            fwd_valid_reg <= w_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        w_addr_reg   <= smp_addr;
        w_delta_reg  <= smp.delta;
        fwd_addr_reg <= w_addr_reg;
        fwd_data_reg <= new_val;
    end
endmodule
